// ===== hdl/pcfm_pkg.sv =====
// Shared types, constants and helpers for the pulse count frequency meter.
`timescale 1ns / 1ps

package pcfm_pkg;

   // Field widths
   localparam int unsigned BCD_W       = 24;
   localparam int unsigned BCD_DIGITS  = 6;
   localparam int unsigned CNT_W       = 20;
   localparam int unsigned TIME_W      = 64;
   localparam int unsigned MAG_W       = 8;
   localparam int unsigned LIMIT_W     = 20;
   localparam int unsigned OUT_W       = 32;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned RPM_W       = 6;

   // Scaling constants
   localparam int unsigned MICROS_PER_SEC        = 1000000;
   localparam int unsigned RPM_PER_HZ            = 60;
   localparam int unsigned DEFAULT_FRACTION_BITS = 8;

   // Register reset values
   localparam logic [LIMIT_W-1:0] RESET_LIMIT_DEFAULT = 20'd500000;
   localparam logic [MAG_W-1:0]   MAGNETS_DEFAULT     = 8'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGNETS     = 1'd1;

   // Saturation limits
   localparam logic [OUT_W-1:0] SAT_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] SAT_NEG_MIN = 32'h8000_0000;
   localparam logic [OUT_W-1:0] SAT_U_MAX   = 32'hFFFF_FFFF;

   localparam logic [3:0] DIGIT_MAX = 4'd9;

   // Status from the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Decode six packed BCD digits; a nibble above nine counts as nine
   function automatic logic [CNT_W-1:0] decode_bcd(input logic [BCD_W-1:0] bcd);
      logic [CNT_W-1:0] value;
      logic [3:0]       digit;
      value = '0;
      for (int i = BCD_DIGITS - 1; i >= 0; i--) begin
         digit = bcd[4*i +: 4];
         if (digit > DIGIT_MAX) begin
            digit = DIGIT_MAX;
         end
         value = CNT_W'(value * CNT_W'(10) + CNT_W'(digit));
      end
      return value;
   endfunction

endpackage

// ===== hdl/pcfm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pcfm_divider
   import pcfm_pkg::*;
#(
   parameter int unsigned NUM_W = 54,
   parameter int unsigned DEN_W = 72
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   numerator,
   input  logic [DEN_W-1:0]   denominator,
   output div_status_type     status,
   output logic [NUM_W-1:0]   quotient
);

   localparam int unsigned STEP_W = $clog2(NUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   // Shift in the next numerator bit and try one subtract
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, denominator};
      fits  = trial >= {1'b0, denominator};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         step_in = LAST_STEP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== hdl/pulse_count_frequency_meter_unit.sv =====
// Frequency meter that turns polled BCD pulse counts and timestamps into Hz and rpm.
//
// Usage: each req beat is one poll of an external six-digit BCD pulse counter together
// with its microsecond timestamp. Each poll yields exactly one rsp beat holding the
// frequency and one-pulse resolution in Hz and rpm (fixed point, FRACTION_BITS
// fraction bits, saturated), a request to clear the external counter and a divide
// error flag. The csr port writes the counter clear threshold and magnets per rev;
// the user must write them only while the block is idle, which the block does not
// enforce; there is no read-back. The sequencer steps through S_DELTA, S_SCALE and
// S_RPM, then the one restoring divider produces all four quotients one bit per
// cycle, each through S_DIV_START and S_DIV_WAIT, and the result goes out in S_DONE;
// a poll with a divide error skips the divider. req_ready is high only when idle.
// A finished result waits in the output register, so the next poll is taken while
// the rsp beat is still stalled; if that stall lasts until the next result is done,
// the block holds the new result until the output register frees up.
// Reset: synchronous, clears previous count and time to zero and restores the
// register defaults (limit 500000, two magnets).

`timescale 1ns / 1ps

module pulse_count_frequency_meter_unit
   import pcfm_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // poll channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BCD_W-1:0]         req_counter_bcd,
   input  logic [TIME_W-1:0]        req_time_us,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_freq_hz_q8,
   output logic signed [OUT_W-1:0]  rsp_freq_rpm_q8,
   output logic [OUT_W-1:0]         rsp_resolution_hz_q8,
   output logic [OUT_W-1:0]         rsp_resolution_rpm_q8,
   output logic                     rsp_reset_counter,
   output logic                     rsp_divide_error,
   // register writes
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   // 1e6 fits in CNT_W bits, 60 in RPM_W bits
   localparam int unsigned BASE_W = CNT_W + FRACTION_BITS;
   localparam int unsigned NUM_W  = BASE_W + CNT_W + RPM_W;
   localparam int unsigned DEN_W  = MAG_W + TIME_W;
   localparam logic [BASE_W-1:0] BASE     = BASE_W'(MICROS_PER_SEC) << FRACTION_BITS;
   localparam logic [NUM_W-1:0]  BASE_NUM = NUM_W'(BASE);
   localparam logic [NUM_W-1:0]  BASE_RPM = NUM_W'(NUM_W'(BASE) * NUM_W'(RPM_PER_HZ));

   // Sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DELTA     = 3'd1;
   localparam logic [2:0] S_SCALE     = 3'd2;
   localparam logic [2:0] S_RPM       = 3'd3;
   localparam logic [2:0] S_DIV_START = 3'd4;
   localparam logic [2:0] S_DIV_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   // Quotient jobs for the shared divider
   localparam logic [1:0] JOB_FHZ  = 2'd0;
   localparam logic [1:0] JOB_FRPM = 2'd1;
   localparam logic [1:0] JOB_RHZ  = 2'd2;
   localparam logic [1:0] JOB_RRPM = 2'd3;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          job_ff, job_in;

   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [MAG_W-1:0]    magnets_ff, magnets_in;
   logic [CNT_W-1:0]    prev_count_ff, prev_count_in;
   logic [TIME_W-1:0]   prev_time_ff, prev_time_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   dt_ff, dt_in;
   logic [CNT_W-1:0]    dmag_ff, dmag_in;
   logic                neg_ff, neg_in;
   logic                clear_ff, clear_in;
   logic                err_ff, err_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    num_f_ff, num_f_in;
   logic [NUM_W-1:0]    num_r_ff, num_r_in;

   logic [OUT_W-1:0]    fhz_ff, fhz_in;
   logic [OUT_W-1:0]    frpm_ff, frpm_in;
   logic [OUT_W-1:0]    rhz_ff, rhz_in;
   logic [OUT_W-1:0]    rrpm_ff, rrpm_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    out_fhz_ff, out_fhz_in;
   logic [OUT_W-1:0]    out_frpm_ff, out_frpm_in;
   logic [OUT_W-1:0]    out_rhz_ff, out_rhz_in;
   logic [OUT_W-1:0]    out_rrpm_ff, out_rrpm_in;
   logic                out_clear_ff, out_clear_in;
   logic                out_err_ff, out_err_in;

   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   div_status_type      div_status;
   logic [NUM_W-1:0]    div_quo;

   logic signed [CNT_W:0]   delta;
   logic signed [CNT_W+1:0] predicted;
   logic [OUT_W-1:0]        sat_signed_q;
   logic [OUT_W-1:0]        sat_unsigned_q;
   logic                    out_free;

   pcfm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (den_ff),
      .status      (div_status),
      .quotient    (div_quo)
   );

   // Count difference and predicted next count
   always_comb begin
      delta     = $signed({1'b0, count_ff}) - $signed({1'b0, prev_count_ff});
      predicted = $signed({2'b00, count_ff}) + (CNT_W+2)'(delta);
   end

   // Clamp the divider quotient to the output range
   always_comb begin
      if (neg_ff) begin
         sat_signed_q = (div_quo >= NUM_W'(SAT_NEG_MIN)) ? SAT_NEG_MIN
                                                         : OUT_W'(0) - div_quo[OUT_W-1:0];
      end else begin
         sat_signed_q = (div_quo > NUM_W'(SAT_POS_MAX)) ? SAT_POS_MAX : div_quo[OUT_W-1:0];
      end
      sat_unsigned_q = (div_quo > NUM_W'(SAT_U_MAX)) ? SAT_U_MAX : div_quo[OUT_W-1:0];
   end

   // Pick the numerator for the current job
   always_comb begin
      unique case (job_ff)
         JOB_FHZ:  div_num = num_f_ff;
         JOB_FRPM: div_num = num_r_ff;
         JOB_RHZ:  div_num = BASE_NUM;
         JOB_RRPM: div_num = BASE_RPM;
         default:  div_num = num_f_ff;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      limit_in      = limit_ff;
      magnets_in    = magnets_ff;
      prev_count_in = prev_count_ff;
      prev_time_in  = prev_time_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      dt_in         = dt_ff;
      dmag_in       = dmag_ff;
      neg_in        = neg_ff;
      clear_in      = clear_ff;
      err_in        = err_ff;
      den_in        = den_ff;
      num_f_in      = num_f_ff;
      num_r_in      = num_r_ff;
      fhz_in        = fhz_ff;
      frpm_in       = frpm_ff;
      rhz_in        = rhz_ff;
      rrpm_in       = rrpm_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_fhz_in    = out_fhz_ff;
      out_frpm_in   = out_frpm_ff;
      out_rhz_in    = out_rhz_ff;
      out_rrpm_in   = out_rrpm_ff;
      out_clear_in  = out_clear_ff;
      out_err_in    = out_err_ff;
      div_start     = 1'b0;

      // take register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RESET_LIMIT: limit_in   = csr_wdata[LIMIT_W-1:0];
            CSR_MAGNETS:     magnets_in = csr_wdata[MAG_W-1:0];
            default:         limit_in   = limit_ff;
         endcase
      end

      // drop the result beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               count_in = decode_bcd(req_counter_bcd);
               time_in  = req_time_us;
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            neg_in   = delta[CNT_W];
            dmag_in  = delta[CNT_W] ? CNT_W'(-delta) : delta[CNT_W-1:0];
            dt_in    = time_ff - prev_time_ff;
            clear_in = $signed({2'b00, limit_ff}) < predicted;
            prev_count_in = ($signed({2'b00, limit_ff}) < predicted) ? '0 : count_ff;
            prev_time_in  = time_ff;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            den_in   = DEN_W'(magnets_ff) * DEN_W'(dt_ff);
            num_f_in = NUM_W'(dmag_ff) * NUM_W'(BASE);
            err_in   = (magnets_ff == '0) || (dt_ff == '0);
            state_in = S_RPM;
         end
         S_RPM: begin
            // times 60 as times 64 minus times 4
            num_r_in = (num_f_ff << 6) - (num_f_ff << 2);
            job_in   = JOB_FHZ;
            state_in = err_ff ? S_DONE : S_DIV_START;
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_status.done) begin
               unique case (job_ff)
                  JOB_FHZ:  fhz_in  = sat_signed_q;
                  JOB_FRPM: frpm_in = sat_signed_q;
                  JOB_RHZ:  rhz_in  = sat_unsigned_q;
                  JOB_RRPM: rrpm_in = sat_unsigned_q;
                  default:  fhz_in  = fhz_ff;
               endcase
               if (job_ff == JOB_RRPM) begin
                  state_in = S_DONE;
               end else begin
                  job_in   = job_ff + 2'd1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_fhz_in   = err_ff ? '0 : fhz_ff;
               out_frpm_in  = err_ff ? '0 : frpm_ff;
               out_rhz_in   = err_ff ? '0 : rhz_ff;
               out_rrpm_in  = err_ff ? '0 : rrpm_ff;
               out_clear_in = clear_ff;
               out_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= RESET_LIMIT_DEFAULT;
         magnets_ff    <= MAGNETS_DEFAULT;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= limit_in;
         magnets_ff    <= magnets_in;
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      count_ff     <= count_in;
      time_ff      <= time_in;
      dt_ff        <= dt_in;
      dmag_ff      <= dmag_in;
      neg_ff       <= neg_in;
      clear_ff     <= clear_in;
      err_ff       <= err_in;
      den_ff       <= den_in;
      num_f_ff     <= num_f_in;
      num_r_ff     <= num_r_in;
      fhz_ff       <= fhz_in;
      frpm_ff      <= frpm_in;
      rhz_ff       <= rhz_in;
      rrpm_ff      <= rrpm_in;
      out_fhz_ff   <= out_fhz_in;
      out_frpm_ff  <= out_frpm_in;
      out_rhz_ff   <= out_rhz_in;
      out_rrpm_ff  <= out_rrpm_in;
      out_clear_ff <= out_clear_in;
      out_err_ff   <= out_err_in;
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_freq_hz_q8        = $signed(out_fhz_ff);
   assign rsp_freq_rpm_q8       = $signed(out_frpm_ff);
   assign rsp_resolution_hz_q8  = out_rhz_ff;
   assign rsp_resolution_rpm_q8 = out_rrpm_ff;
   assign rsp_reset_counter     = out_clear_ff;
   assign rsp_divide_error      = out_err_ff;

endmodule

// ===== hdl/pcfm_checker.sv =====
// Port-level checks for the frequency meter, bound to the top level.
`timescale 1ns / 1ps

module pcfm_checker
   import pcfm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_freq_hz_q8,
   input logic signed [OUT_W-1:0] rsp_freq_rpm_q8,
   input logic [OUT_W-1:0]        rsp_resolution_hz_q8,
   input logic [OUT_W-1:0]        rsp_resolution_rpm_q8,
   input logic                    rsp_divide_error
);

   // a poll moves the block out of idle when taken, so no beat follows right after one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a poll was taken");

   // a divide error zeroes every measured value
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |->
         rsp_freq_hz_q8 == '0 && rsp_freq_rpm_q8 == '0 &&
         rsp_resolution_hz_q8 == '0 && rsp_resolution_rpm_q8 == '0)
      else $error("nonzero value with divide error");

   // rpm carries the sign of Hz; rpm resolution is never below Hz resolution
   a_rpm_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_freq_hz_q8[OUT_W-1] |-> rsp_freq_rpm_q8[OUT_W-1])
      else $error("negative Hz with nonnegative rpm");

   a_rpm_resolution: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_resolution_rpm_q8 >= rsp_resolution_hz_q8)
      else $error("rpm resolution below Hz resolution");

   // stalled result beat stays valid and keeps its Hz values
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_freq_hz_q8) &&
         $stable(rsp_resolution_hz_q8))
      else $error("result beat changed while stalled");

endmodule

bind pulse_count_frequency_meter_unit pcfm_checker u_pcfm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_freq_hz_q8        (rsp_freq_hz_q8),
   .rsp_freq_rpm_q8       (rsp_freq_rpm_q8),
   .rsp_resolution_hz_q8  (rsp_resolution_hz_q8),
   .rsp_resolution_rpm_q8 (rsp_resolution_rpm_q8),
   .rsp_divide_error      (rsp_divide_error)
);
